// ===== rtl/cmh_pkg.sv =====
// ============================================================================
// cmh_pkg: shared types and constants for the Cayley matrix hash unit
// Field prime, generator entries and the controller/datapath command types.
// ============================================================================
package cmh_pkg;

   localparam logic [255:0] FieldP =
      {192'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF,
       64'hFFFFFFFF_FFFF72EF};
   localparam logic [255:0] FieldPm2 = FieldP - 256'd2;
   localparam logic [16:0]  FoldC = 17'd36113;

   typedef logic [255:0] fe_type;

   // Generator entries in column-major order.
   localparam fe_type GenA0 = FieldP - 256'd2;
   localparam fe_type GenA1 = 256'd4;
   localparam fe_type GenA2 = 256'd1;
   localparam fe_type GenA3 = FieldP - 256'd3;
   localparam fe_type GenB0 = FieldP - 256'd5;
   localparam fe_type GenB1 = FieldP - 256'd6;
   localparam fe_type GenB2 = 256'd2;
   localparam fe_type GenB3 = 256'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BIT_MUL,
      ST_BIT_WAIT,
      ST_BIT_ADD,
      ST_BIT_STORE,
      ST_INV_START,
      ST_INV_MUL,
      ST_INV_WAIT,
      ST_INV_STORE,
      ST_OUT
   } state_type;

   // Steps of the iterative multiplier.
   typedef enum logic [1:0] {
      MM_IDLE,
      MM_MAC,
      MM_FOLD,
      MM_FINISH
   } mul_state_type;

   // Operand selects of the shared multiplier.
   typedef enum logic [1:0] {
      SEL_MAT_GEN,
      SEL_ACC_BASE,
      SEL_BASE_BASE
   } msel_type;

   typedef struct packed {
      logic       mul_start;
      msel_type   mul_sel;
      logic [1:0] entry;      // result entry of the matrix product
      logic       term;       // which product of the pair
      logic       gen_b;      // generator B when set
      logic       add_pair;   // add the two products into the new matrix
      logic       commit;     // new matrix becomes current
      logic       set_ident;  // matrix back to identity
      logic       inv_load;   // load base and accumulator for entry
      logic       acc_write;  // product to accumulator
      logic       base_write; // product to base
      logic       inv_store;  // accumulator to inverse store
   } cmd_type;

   typedef struct packed {
      logic mul_done;
   } status_type;

endpackage

// ===== rtl/cayley_matrix_hash_gl2_fp256_unit.sv =====
// ============================================================================
// cayley_matrix_hash_gl2_fp256_unit: Cayley-graph hash over GL(2, GF(p))
// Multiplies a 2x2 matrix by one of two generators per message bit and, on
// the last word of a message, emits the entrywise inverses as 16 limbs.
// ============================================================================
// Each modular multiply holds the shared multiplier until done; a message bit
// is eight multiplies, four adds and one commit, and a new word is taken only
// once every bit of the previous one is through.
// A final word adds the inversion (256 squarings and 250 multiplies per
// entry), then 16 output words at one a cycle unless stalled.
// One word at a time; synchronous reset returns to idle at the identity.
module cayley_matrix_hash_gl2_fp256_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_msg_byte,
   input  logic [3:0]  req_valid_bits,
   input  logic        req_final_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_word,
   output logic [3:0]  rsp_word_index,
   output logic        rsp_last_word
);

   // The controller sequences; the datapath holds the matrix, the product
   // pair, the exponentiation registers and the inverse store.
   cmh_pkg::cmd_type    cmd;
   cmh_pkg::status_type status;

   cmh_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_msg_byte   (req_msg_byte),
      .req_valid_bits (req_valid_bits),
      .req_final_item (req_final_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word_index (rsp_word_index),
      .rsp_last_word  (rsp_last_word),
      .cmd            (cmd),
      .status         (status)
   );

   // The output word is read straight from the inverse store by word index.
   cmh_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .rd_index (rsp_word_index),
      .status   (status),
      .rd_word  (rsp_digest_word)
   );

endmodule

// ===== rtl/cmh_mulmod.sv =====
// ============================================================================
// cmh_mulmod: iterative 256-bit modular multiplier
// Horner over 32-bit digits of b with 32x32 multiply-accumulate steps.
// ============================================================================
module cmh_mulmod (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  cmh_pkg::fe_type       op_a,
   input  cmh_pkg::fe_type       op_b,
   output logic                  done,
   output cmh_pkg::fe_type       result
);

   // Horner over eight 32-bit digits of b, most significant first:
   // acc = (acc*2^32 + a*digit) mod p. Each digit runs one 32x32
   // multiply-accumulate per digit of a, least significant first (MM_MAC),
   // then a step folding the bits above 2^256 back in (2^256 == FoldC mod p)
   // (MM_FOLD) and a step for the final conditional subtract of p (MM_FINISH).
   // done pulses in the cycle after the last digit's subtract, as result holds the product.
   cmh_pkg::mul_state_type state_ff, state_in;
   logic [2:0]      dig_ff, dig_in;
   logic [2:0]      col_ff, col_in;
   cmh_pkg::fe_type a_ff, a_in, b_ff, b_in, acc_ff, acc_in;
   cmh_pkg::fe_type part_ff, part_in;
   logic [31:0]     carry_ff, carry_in;
   logic [256:0]    fold_ff, fold_in;
   logic            done_ff, done_in;

   logic [31:0]     a_dig;
   logic [31:0]     sh_dig;
   logic [63:0]     mac;
   logic [32:0]     top;
   logic [48:0]     top_fold;
   logic            over;
   cmh_pkg::fe_type red;

   always_comb begin
      // One digit of a*digit + acc*2^32 plus the running carry; fits 64 bits.
      a_dig  = a_ff[{col_ff, 5'd0} +: 32];
      sh_dig = (col_ff == 3'd0) ? 32'd0 : acc_ff[{col_ff - 3'd1, 5'd0} +: 32];
      mac    = ({32'd0, a_dig} * {32'd0, b_ff[255:224]}) + {32'd0, sh_dig}
               + {32'd0, carry_ff};
      // Bits above 2^256 of the partial result: top acc digit plus last carry.
      top      = {1'b0, acc_ff[255:224]} + {1'b0, carry_ff};
      top_fold = 49'(top * cmh_pkg::FoldC);
      // Subtracting p is adding FoldC modulo 2^256.
      over = fold_ff[256] || (fold_ff[255:0] >= cmh_pkg::FieldP);
      red  = over ? (fold_ff[255:0] + {239'd0, cmh_pkg::FoldC}) : fold_ff[255:0];
   end

   always_comb begin
      state_in = state_ff;
      dig_in   = dig_ff;
      col_in   = col_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      part_in  = part_ff;
      carry_in = carry_ff;
      fold_in  = fold_ff;
      done_in  = 1'b0;
      if (start) begin
         state_in = cmh_pkg::MM_MAC;
         dig_in   = 3'd0;
         col_in   = 3'd0;
         a_in     = op_a;
         b_in     = op_b;
         acc_in   = '0;
         carry_in = '0;
      end else begin
         unique case (state_ff)
            cmh_pkg::MM_IDLE: begin
            end
            cmh_pkg::MM_MAC: begin
               part_in  = {mac[31:0], part_ff[255:32]};
               carry_in = mac[63:32];
               col_in   = col_ff + 3'd1;
               if (col_ff == 3'd7) begin
                  state_in = cmh_pkg::MM_FOLD;
               end
            end
            cmh_pkg::MM_FOLD: begin
               fold_in  = {1'b0, part_ff} + {208'd0, top_fold};
               state_in = cmh_pkg::MM_FINISH;
            end
            cmh_pkg::MM_FINISH: begin
               acc_in   = red;
               b_in     = {b_ff[223:0], 32'd0};
               carry_in = '0;
               dig_in   = dig_ff + 3'd1;
               if (dig_ff == 3'd7) begin
                  state_in = cmh_pkg::MM_IDLE;
                  done_in  = 1'b1;
               end else begin
                  state_in = cmh_pkg::MM_MAC;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cmh_pkg::MM_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      dig_ff   <= dig_in;
      col_ff   <= col_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      acc_ff   <= acc_in;
      part_ff  <= part_in;
      carry_ff <= carry_in;
      fold_ff  <= fold_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

// ===== rtl/cmh_datapath.sv =====
// ============================================================================
// cmh_datapath: matrix, product and inversion registers of the hash unit
// Runs the commands of the controller around one shared multiplier.
// ============================================================================
module cmh_datapath (
   input  logic                clock,
   input  logic                reset,
   input  cmh_pkg::cmd_type    cmd,
   input  logic [3:0]          rd_index,
   output cmh_pkg::status_type status,
   output logic [63:0]         rd_word
);

   cmh_pkg::fe_type mat_ff [4];
   cmh_pkg::fe_type nmat_ff [4];
   cmh_pkg::fe_type inv_ff [4];
   cmh_pkg::fe_type t0_ff, t1_ff;
   cmh_pkg::fe_type base_ff, acc_ff;

   cmh_pkg::fe_type gen_e, mat_e, op_a, op_b, prod;
   logic            mul_done;
   logic [256:0]    sum;
   cmh_pkg::fe_type sum_r;
   logic [1:0]      mat_sel, gen_sel;

   // Product entry r = x[row] * y[k] + x[row+2] * y[k+1], column-major.
   always_comb begin
      mat_sel = {cmd.term, cmd.entry[0]};
      gen_sel = {cmd.entry[1], cmd.term};
      mat_e   = mat_ff[mat_sel];
      unique case (gen_sel)
         2'd0:    gen_e = cmd.gen_b ? cmh_pkg::GenB0 : cmh_pkg::GenA0;
         2'd1:    gen_e = cmd.gen_b ? cmh_pkg::GenB1 : cmh_pkg::GenA1;
         2'd2:    gen_e = cmd.gen_b ? cmh_pkg::GenB2 : cmh_pkg::GenA2;
         default: gen_e = cmd.gen_b ? cmh_pkg::GenB3 : cmh_pkg::GenA3;
      endcase
      unique case (cmd.mul_sel)
         cmh_pkg::SEL_MAT_GEN:  begin op_a = mat_e;   op_b = gen_e;   end
         cmh_pkg::SEL_ACC_BASE: begin op_a = acc_ff;  op_b = base_ff; end
         default:               begin op_a = base_ff; op_b = base_ff; end
      endcase
      sum   = {1'b0, t0_ff} + {1'b0, t1_ff};
      sum_r = sum[255:0];
      if (sum[256] || sum_r >= cmh_pkg::FieldP) begin
         sum_r = sum_r - cmh_pkg::FieldP;
      end
   end

   cmh_mulmod u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mul_start),
      .op_a   (op_a),
      .op_b   (op_b),
      .done   (mul_done),
      .result (prod)
   );

   always_ff @(posedge clock) begin
      if (reset || cmd.set_ident) begin
         mat_ff[0] <= 256'd1;
         mat_ff[1] <= '0;
         mat_ff[2] <= '0;
         mat_ff[3] <= 256'd1;
      end else if (cmd.commit) begin
         for (int i = 0; i < 4; i++) begin
            mat_ff[i] <= nmat_ff[i];
         end
      end
      if (mul_done && cmd.mul_sel == cmh_pkg::SEL_MAT_GEN) begin
         if (cmd.term) begin
            t1_ff <= prod;
         end else begin
            t0_ff <= prod;
         end
      end
      if (cmd.add_pair) begin
         nmat_ff[cmd.entry] <= sum_r;
      end
      if (cmd.inv_load) begin
         base_ff <= mat_ff[cmd.entry];
         acc_ff  <= 256'd1;
      end else begin
         if (cmd.acc_write) begin
            acc_ff <= prod;
         end
         if (cmd.base_write) begin
            base_ff <= prod;
         end
      end
      if (cmd.inv_store) begin
         inv_ff[cmd.entry] <= (mat_ff[cmd.entry] == '0) ? '0 : acc_ff;
      end
   end

   assign status.mul_done = mul_done;
   assign rd_word = inv_ff[rd_index[3:2]][rd_index[1:0]*64 +: 64];

endmodule

// ===== rtl/cmh_ctrl.sv =====
// ============================================================================
// cmh_ctrl: sequencer of the Cayley matrix hash unit
// Walks message bits, product entries, exponent bits and output words.
// ============================================================================
module cmh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_msg_byte,
   input  logic [3:0]          req_valid_bits,
   input  logic                req_final_item,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [3:0]          rsp_word_index,
   output logic                rsp_last_word,
   output cmh_pkg::cmd_type    cmd,
   input  cmh_pkg::status_type status
);

   cmh_pkg::state_type state_ff, state_in;
   logic [7:0] byte_ff, byte_in;
   logic [3:0] left_ff, left_in;
   logic       fin_ff, fin_in;
   logic [1:0] entry_ff, entry_in;
   logic       term_ff, term_in;
   logic [7:0] ebit_ff, ebit_in;
   logic       phase_ff, phase_in;   // 0: acc*base, 1: base*base
   logic [3:0] word_ff, word_in;
   logic       exp_bit;

   always_comb begin
      exp_bit   = cmh_pkg::FieldPm2[ebit_ff];
      state_in  = state_ff;
      byte_in   = byte_ff;
      left_in   = left_ff;
      fin_in    = fin_ff;
      entry_in  = entry_ff;
      term_in   = term_ff;
      ebit_in   = ebit_ff;
      phase_in  = phase_ff;
      word_in   = word_ff;
      cmd       = '0;
      cmd.entry = entry_ff;
      cmd.term  = term_ff;
      cmd.gen_b = byte_ff[7];
      cmd.mul_sel = cmh_pkg::SEL_MAT_GEN;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         cmh_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               byte_in  = req_msg_byte;
               left_in  = (req_valid_bits > 4'd8) ? 4'd8 : req_valid_bits;
               fin_in   = req_final_item;
               entry_in = 2'd0;
               term_in  = 1'b0;
               state_in = cmh_pkg::ST_BIT_MUL;
            end
         end
         cmh_pkg::ST_BIT_MUL: begin
            if (left_ff == 4'd0) begin
               entry_in = 2'd0;
               state_in = fin_ff ? cmh_pkg::ST_INV_START : cmh_pkg::ST_IDLE;
            end else begin
               cmd.mul_start = 1'b1;
               state_in = cmh_pkg::ST_BIT_WAIT;
            end
         end
         cmh_pkg::ST_BIT_WAIT: begin
            if (status.mul_done) begin
               if (term_ff) begin
                  term_in  = 1'b0;
                  state_in = cmh_pkg::ST_BIT_ADD;
               end else begin
                  term_in  = 1'b1;
                  state_in = cmh_pkg::ST_BIT_MUL;
               end
            end
         end
         cmh_pkg::ST_BIT_ADD: begin
            cmd.add_pair = 1'b1;
            entry_in = entry_ff + 2'd1;
            state_in = (entry_ff == 2'd3) ? cmh_pkg::ST_BIT_STORE : cmh_pkg::ST_BIT_MUL;
         end
         cmh_pkg::ST_BIT_STORE: begin
            cmd.commit = 1'b1;
            byte_in  = {byte_ff[6:0], 1'b0};
            left_in  = left_ff - 4'd1;
            state_in = cmh_pkg::ST_BIT_MUL;
         end
         cmh_pkg::ST_INV_START: begin
            cmd.inv_load = 1'b1;
            ebit_in  = 8'd0;
            phase_in = 1'b0;
            state_in = cmh_pkg::ST_INV_MUL;
         end
         cmh_pkg::ST_INV_MUL: begin
            if (!phase_ff && !exp_bit) begin
               phase_in = 1'b1;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel = phase_ff ? cmh_pkg::SEL_BASE_BASE : cmh_pkg::SEL_ACC_BASE;
               state_in = cmh_pkg::ST_INV_WAIT;
            end
         end
         cmh_pkg::ST_INV_WAIT: begin
            cmd.mul_sel = phase_ff ? cmh_pkg::SEL_BASE_BASE : cmh_pkg::SEL_ACC_BASE;
            if (status.mul_done) begin
               if (phase_ff) begin
                  cmd.base_write = 1'b1;
                  phase_in = 1'b0;
                  ebit_in  = ebit_ff + 8'd1;
                  state_in = (ebit_ff == 8'd255) ? cmh_pkg::ST_INV_STORE
                                                 : cmh_pkg::ST_INV_MUL;
               end else begin
                  cmd.acc_write = 1'b1;
                  phase_in = 1'b1;
                  state_in = cmh_pkg::ST_INV_MUL;
               end
            end
         end
         cmh_pkg::ST_INV_STORE: begin
            cmd.inv_store = 1'b1;
            entry_in = entry_ff + 2'd1;
            word_in  = 4'd0;
            state_in = (entry_ff == 2'd3) ? cmh_pkg::ST_OUT : cmh_pkg::ST_INV_START;
            if (entry_ff == 2'd3) begin
               cmd.set_ident = 1'b1;
            end
         end
         cmh_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               word_in = word_ff + 4'd1;
               if (word_ff == 4'd15) begin
                  state_in = cmh_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = cmh_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cmh_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      byte_ff  <= byte_in;
      left_ff  <= left_in;
      fin_ff   <= fin_in;
      entry_ff <= entry_in;
      term_ff  <= term_in;
      ebit_ff  <= ebit_in;
      phase_ff <= phase_in;
      word_ff  <= word_in;
   end

   assign rsp_word_index = word_ff;
   assign rsp_last_word  = (word_ff == 4'd15);

endmodule

// ===== tb/tb_cayley_matrix_hash_gl2_fp256_unit.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_cayley_matrix_hash_gl2_fp256_unit: self-checking bench for the hash unit
// Streams message words with random handshake gaps and compares every digest
// word against a bit-exact predictor of the matrix walk and the inversion.
// ============================================================================
module tb_cayley_matrix_hash_gl2_fp256_unit;

   // One expected digest word.
   typedef struct {
      logic [63:0] limb;
      logic [3:0]  index;
      logic        last;
   } digest_word_type;

   // The scoreboard keeps its own copy of the running matrix. Entries are in
   // column-major order, the same order in which the digest is emitted.
   class digest_scoreboard;
      cmh_pkg::fe_type walk_matrix[4];
      digest_word_type pending_words[$];
      int unsigned     mismatches;
      int unsigned     words_checked;
      int unsigned     messages_done;

      function new();
         mismatches    = 0;
         words_checked = 0;
         messages_done = 0;
         set_identity();
      endfunction

      function void set_identity();
         walk_matrix[0] = 256'd1;
         walk_matrix[1] = 256'd0;
         walk_matrix[2] = 256'd0;
         walk_matrix[3] = 256'd1;
      endfunction

      function cmh_pkg::fe_type field_mul(cmh_pkg::fe_type a, cmh_pkg::fe_type b);
         logic [511:0] wide;
         wide = {256'd0, a} * {256'd0, b};
         wide = wide % {256'd0, cmh_pkg::FieldP};
         return wide[255:0];
      endfunction

      function cmh_pkg::fe_type field_add(cmh_pkg::fe_type a, cmh_pkg::fe_type b);
         logic [256:0] sum;
         sum = {1'b0, a} + {1'b0, b};
         if (sum >= {1'b0, cmh_pkg::FieldP}) begin
            sum = sum - {1'b0, cmh_pkg::FieldP};
         end
         return sum[255:0];
      endfunction

      // Fermat inverse; zero maps to zero.
      function cmh_pkg::fe_type field_inverse(cmh_pkg::fe_type a);
         cmh_pkg::fe_type acc;
         cmh_pkg::fe_type base;
         acc  = 256'd1;
         base = a;
         if (a == 256'd0) begin
            return 256'd0;
         end
         for (int i = 0; i < 256; i++) begin
            if (cmh_pkg::FieldPm2[i]) begin
               acc = field_mul(acc, base);
            end
            base = field_mul(base, base);
         end
         return acc;
      endfunction

      // Right-multiply the running matrix by generator A or B.
      function void step_generator(logic use_b);
         cmh_pkg::fe_type g[4];
         cmh_pkg::fe_type x[4];
         if (use_b) begin
            g = '{cmh_pkg::GenB0, cmh_pkg::GenB1, cmh_pkg::GenB2, cmh_pkg::GenB3};
         end else begin
            g = '{cmh_pkg::GenA0, cmh_pkg::GenA1, cmh_pkg::GenA2, cmh_pkg::GenA3};
         end
         x = walk_matrix;
         walk_matrix[0] = field_add(field_mul(x[0], g[0]), field_mul(x[2], g[1]));
         walk_matrix[1] = field_add(field_mul(x[1], g[0]), field_mul(x[3], g[1]));
         walk_matrix[2] = field_add(field_mul(x[0], g[2]), field_mul(x[2], g[3]));
         walk_matrix[3] = field_add(field_mul(x[1], g[2]), field_mul(x[3], g[3]));
      endfunction

      // Called for every accepted input word.
      function void note_input(logic [7:0] msg, logic [3:0] nbits, logic fin);
         int unsigned     used;
         cmh_pkg::fe_type inv;
         digest_word_type w;
         used = (nbits > 4'd8) ? 8 : nbits;
         for (int k = 0; k < used; k++) begin
            step_generator(msg[7 - k]);
         end
         if (fin) begin
            for (int e = 0; e < 4; e++) begin
               inv = field_inverse(walk_matrix[e]);
               for (int l = 0; l < 4; l++) begin
                  w.limb  = inv[64*l +: 64];
                  w.index = 4'(e * 4 + l);
                  w.last  = (e == 3 && l == 3);
                  pending_words.push_back(w);
               end
            end
            set_identity();
            messages_done++;
         end
      endfunction

      // Called for every accepted result word.
      function void check_result(logic [63:0] limb, logic [3:0] index, logic last);
         digest_word_type w;
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: unexpected digest word index=%0d limb=%h", index, limb);
            end
            return;
         end
         w = pending_words.pop_front();
         words_checked++;
         if (w.limb !== limb || w.index !== index || w.last !== last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: digest word mismatch: expected idx=%0d last=%0d %h,",
                        w.index, w.last, w.limb);
               $display("       got idx=%0d last=%0d %h", index, last, limb);
            end
         end
      endfunction
   endclass

   localparam int unsigned CycleLimit = 200_000_000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_msg_byte;
   logic [3:0]  req_valid_bits;
   logic        req_final_item;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_digest_word;
   logic [3:0]  rsp_word_index;
   logic        rsp_last_word;

   digest_scoreboard scoreboard;
   int unsigned      sender_idle_pct;
   int unsigned      receiver_idle_pct;
   int unsigned      cycle_count;
   int unsigned      words_sent;

   cayley_matrix_hash_gl2_fp256_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_msg_byte   (req_msg_byte),
      .req_valid_bits (req_valid_bits),
      .req_final_item (req_final_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digest_word(rsp_digest_word),
      .rsp_word_index (rsp_word_index),
      .rsp_last_word  (rsp_last_word)
   );

   // 20 ns clock.
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The receiver stalls at random with the current idle percentage. Stall is
   // drawn every cycle, independent of valid, so stalls hit every phase of
   // the output burst.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   // A result word is taken on any edge where valid is high and stall low.
   // Values read here are the ones from before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         scoreboard.check_result(rsp_digest_word, rsp_word_index, rsp_last_word);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("ERROR: timeout after %0d cycles", cycle_count);
         $display("tb_cayley_matrix_hash_gl2_fp256_unit: errors");
         $finish;
      end
   end

   // Present one word and hold it until the block takes it. Valid stays high
   // from one word to the next unless an idle gap is drawn.
   task automatic send_word(logic [7:0] msg, logic [3:0] nbits, logic fin);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_msg_byte   <= msg;
      req_valid_bits <= nbits;
      req_final_item <= fin;
      do begin
         @(posedge clock);
      end while (req_stall);
      scoreboard.note_input(msg, nbits, fin);
      words_sent++;
   endtask

   // Random message words. Most carry a full or partial byte; a few use the
   // saturating bit counts or zero. About one word in twenty ends a message.
   task automatic send_random(int unsigned count);
      logic [3:0] nbits;
      int unsigned pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            nbits = 4'($urandom_range(15, 9));
         end else if (pick < 13) begin
            nbits = 4'd0;
         end else begin
            nbits = 4'($urandom_range(8, 1));
         end
         send_word(8'($urandom), nbits, ($urandom_range(19) == 0));
      end
      // Close the open message so each phase ends on a digest.
      send_word(8'($urandom), 4'($urandom_range(8)), 1'b1);
   endtask

   initial begin
      scoreboard        = new();
      cycle_count       = 0;
      words_sent        = 0;
      sender_idle_pct   = 32;
      receiver_idle_pct = 51;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_msg_byte   <= 8'd0;
      req_valid_bits <= 4'd0;
      req_final_item <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words. An empty message on the identity matrix gives zero
      // off-diagonal entries, whose inverses must come out as zero.
      send_word(8'hFF, 4'd0, 1'b1);
      send_word(8'h00, 4'd8, 1'b0);
      send_word(8'hFF, 4'd8, 1'b1);
      // Bit counts above eight saturate to the whole byte.
      send_word(8'hA5, 4'd9, 1'b0);
      send_word(8'h5A, 4'd15, 1'b0);
      send_word(8'h3C, 4'd12, 1'b1);
      // Zero-bit words change nothing; trailing bits past the count are ignored.
      send_word(8'h81, 4'd0, 1'b0);
      send_word(8'hA5, 4'd3, 1'b0);
      send_word(8'h7F, 4'd1, 1'b0);
      send_word(8'h80, 4'd1, 1'b0);
      send_word(8'hC3, 4'd7, 1'b1);
      // A single generator of each kind.
      send_word(8'h00, 4'd1, 1'b1);
      send_word(8'hFF, 4'd1, 1'b1);

      send_random(90);
      sender_idle_pct   = 51;
      receiver_idle_pct = 32;
      send_random(100);
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      send_random(100);
      req_valid <= 1'b0;

      // Drain the digests still owed, then give the block time to show any
      // stray word.
      while (scoreboard.pending_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (200) @(posedge clock);

      $display("Sent %0d message words making %0d messages; checked %0d digest words.",
               words_sent, scoreboard.messages_done, scoreboard.words_checked);
      $display("Handshake gaps covered sender-heavy, receiver-heavy and gap-free phases.");
      if (scoreboard.mismatches == 0 && scoreboard.pending_words.size() == 0) begin
         $display("tb_cayley_matrix_hash_gl2_fp256_unit: clean");
      end else begin
         $display("Mismatches: %0d", scoreboard.mismatches);
         $display("tb_cayley_matrix_hash_gl2_fp256_unit: errors");
      end
      $finish;
   end

endmodule
